// File: hw/rtl/neighbor_rssi_average_table_core_defines.svh
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is active.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_RSSI_AVERAGE_TABLE_CORE_DEFINES_SVH
`define NEIGHBOR_RSSI_AVERAGE_TABLE_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define NRAT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define NRAT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: hw/rtl/nrat_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: package
// Field widths, table entry layout, item kinds, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nrat_pkg;

  // Field widths.
  localparam int NODE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 24;
  localparam int RSSI_W  = 8;

  // Default table size.
  localparam int TABLE_ENTRIES_DEF = 16;

  // Largest packet count before an entry restarts.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // One table entry as stored in memory.
  typedef struct packed {
    logic        [NODE_W-1:0]  node;
    logic        [COUNT_W-1:0] count;
    logic signed [SUM_W-1:0]   sum;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_DIVIDE,
    ST_EMIT,
    ST_ALLOC,
    ST_EMPTY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic wr_update;
    logic wr_alloc;
    logic fill_inc;
    logic fill_clr;
    logic div_start;
    logic out_load;
    logic out_empty;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_report;
    logic in_id_zero;
    logic op_report;
    logic fill_zero;
    logic fill_full;
    logic hit;
    logic idx_last;
    logic div_done;
  } dp_status_t;

endpackage

// File: hw/rtl/nrat_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module nrat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/nrat_div.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: sequential divider
// Divides a signed sum by an unsigned count one quotient bit per cycle and
// truncates toward zero. Returns the low bits of the quotient.
// ----------------------------------------------------------------------------
module nrat_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [nrat_pkg::SUM_W-1:0]  dividend,
  input  logic        [nrat_pkg::COUNT_W-1:0] divisor,
  output logic signed [nrat_pkg::RSSI_W-1:0] quotient,
  output logic                               done
);
  import nrat_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int REM_W  = COUNT_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [COUNT_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  diff;
  logic [SUM_W-1:0]  q_signed;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_r[REM_W-2:0], acc_r[SUM_W-1]};
    diff    = shifted - {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      // Work on the magnitude and remember the sign.
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = STEP_W'(SUM_W);
      acc_nxt  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      if (!diff[REM_W-1]) begin
        rem_nxt = diff;
        acc_nxt = {acc_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        acc_nxt = {acc_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Apply the sign to the magnitude quotient.
  assign q_signed = neg_r ? (~acc_r + SUM_W'(1)) : acc_r;
  assign quotient = q_signed[RSSI_W-1:0];
  assign done     = done_r;

endmodule

// File: hw/rtl/nrat_dp.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: datapath
// Holds the accepted item, the walk index and fill count, the entry memory,
// the divider and the result register.
// ----------------------------------------------------------------------------
module nrat_dp #(
  parameter int TABLE_ENTRIES = nrat_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_kind,
  input  logic        [nrat_pkg::NODE_W-1:0]  in_sender_id,
  input  logic signed [nrat_pkg::RSSI_W-1:0]  in_rssi_sample,
  input  nrat_pkg::dp_cmd_t                   cmd,
  output nrat_pkg::dp_status_t                status,
  output logic        [nrat_pkg::NODE_W-1:0]  out_neighbor_id,
  output logic signed [nrat_pkg::RSSI_W-1:0]  out_average_rssi,
  output logic                                out_is_empty,
  output logic                                out_last_of_run
);
  import nrat_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic                     kind_r;
  logic [NODE_W-1:0]        id_r;
  logic signed [RSSI_W-1:0] rssi_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;

  logic [ENTRY_W-1:0]       ram_rdata;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]         ram_waddr;
  entry_t                   rd_entry;
  entry_t                   upd_entry;
  entry_t                   new_entry;
  logic signed [SUM_W-1:0]  rssi_ext;
  logic signed [RSSI_W-1:0] div_quot;
  logic                     div_done;
  logic                     idx_last;

  logic [NODE_W-1:0]        out_id_r;
  logic signed [RSSI_W-1:0] out_avg_r;
  logic                     out_empty_r;
  logic                     out_last_r;

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      kind_r <= in_kind;
      id_r   <= in_sender_id;
      rssi_r <= in_rssi_sample;
    end
  end

  // Walk index and fill count. Used entries always form a prefix of the table.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    fill_nxt = fill_r;
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.fill_inc) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
    end
  end

  // New entry contents for a hit and for a fresh allocation.
  assign rssi_ext = SUM_W'(rssi_r);
  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    upd_entry.node = id_r;
    if (rd_entry.count == COUNT_MAX) begin
      upd_entry.count = COUNT_W'(1);
      upd_entry.sum   = rssi_ext;
    end else begin
      upd_entry.count = rd_entry.count + COUNT_W'(1);
      upd_entry.sum   = rd_entry.sum + rssi_ext;
    end
    new_entry.node  = id_r;
    new_entry.count = COUNT_W'(1);
    new_entry.sum   = rssi_ext;
  end

  assign ram_wdata = cmd.wr_alloc ? ENTRY_W'(new_entry) : ENTRY_W'(upd_entry);
  assign ram_waddr = cmd.wr_alloc ? fill_r[IDX_W-1:0] : idx_r;

  nrat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_alloc | cmd.wr_update),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // Average of the entry just read.
  nrat_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(rd_entry.sum),
    .divisor (rd_entry.count),
    .quotient(div_quot),
    .done    (div_done)
  );

  assign idx_last = (CNT_W'(idx_r) + CNT_W'(1)) == fill_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_id_r    <= '0;
        out_avg_r   <= '0;
        out_empty_r <= 1'b1;
        out_last_r  <= 1'b1;
      end else begin
        out_id_r    <= rd_entry.node;
        out_avg_r   <= div_quot;
        out_empty_r <= 1'b0;
        out_last_r  <= idx_last;
      end
    end
  end

  assign out_neighbor_id  = out_id_r;
  assign out_average_rssi = out_avg_r;
  assign out_is_empty     = out_empty_r;
  assign out_last_of_run  = out_last_r;

  // Status toward the controller.
  always_comb begin
    status.in_report  = (in_kind == KIND_REPORT);
    status.in_id_zero = (in_sender_id == '0);
    status.op_report  = (kind_r == KIND_REPORT);
    status.fill_zero  = (fill_r == '0);
    status.fill_full  = (fill_r == CNT_W'(TABLE_ENTRIES));
    status.hit        = (rd_entry.node == id_r);
    status.idx_last   = idx_last;
    status.div_done   = div_done;
  end

endmodule

// File: hw/rtl/nrat_ctrl.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: controller
// Sequences lookups, allocations and report walks, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module nrat_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  nrat_pkg::dp_status_t status,
  output nrat_pkg::dp_cmd_t    cmd
);
  import nrat_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new item when empty or being emptied.
  assign out_free = !out_valid_r || out_ready;

  // State and result flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          cmd.idx_clr = 1'b1;
          if (status.in_report) begin
            state_nxt = status.fill_zero ? ST_EMPTY : ST_READ;
          end else if (!status.in_id_zero) begin
            state_nxt = status.fill_zero ? ST_ALLOC : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (status.op_report) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else if (status.hit) begin
          cmd.wr_update = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (status.idx_last) begin
          // Unknown sender: take the next free entry, or drop when full.
          state_nxt = status.fill_full ? ST_IDLE : ST_ALLOC;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.idx_last) begin
            // The report empties the table.
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_ALLOC: begin
        cmd.wr_alloc = 1'b1;
        cmd.fill_inc = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_EMPTY: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_empty = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/neighbor_rssi_average_table_core.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table core
// Counts RSSI samples per neighbor node and reports per-node averages.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A sample walks the used entries of the
// table through its single-read-port memory, a read and a compare per entry,
// and ends in one write, or in none when its sender is unknown and the table
// is full; a sample with sender id zero is ignored. For each used entry a
// report reads, compares, divides in the bit-serial divider (one quotient
// bit per cycle over the 24-bit sum) and loads the result, waiting while the
// result side holds off; an empty table answers with a single empty marker.
// Clearing the table at the end of a report is immediate. A waiting final
// result does not hold off the next item.
module neighbor_rssi_average_table_core #(
  parameter int TABLE_ENTRIES = nrat_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic        [nrat_pkg::NODE_W-1:0] in_sender_id,
  input  logic signed [nrat_pkg::RSSI_W-1:0] in_rssi_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [nrat_pkg::NODE_W-1:0] out_neighbor_id,
  output logic signed [nrat_pkg::RSSI_W-1:0] out_average_rssi,
  output logic                               out_is_empty,
  output logic                               out_last_of_run
);
  import nrat_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nrat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nrat_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_sender_id    (in_sender_id),
    .in_rssi_sample  (in_rssi_sample),
    .cmd             (cmd),
    .status          (status),
    .out_neighbor_id (out_neighbor_id),
    .out_average_rssi(out_average_rssi),
    .out_is_empty    (out_is_empty),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: hw/rtl/nrat_checker.sv
// ----------------------------------------------------------------------------
// Neighbor RSSI average table: port checker
// Watches the top level's ports and checks result framing and flow.
// ----------------------------------------------------------------------------
`include "neighbor_rssi_average_table_core_defines.svh"

module nrat_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_kind,
  input logic        [nrat_pkg::NODE_W-1:0] in_sender_id,
  input logic signed [nrat_pkg::RSSI_W-1:0] in_rssi_sample,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [nrat_pkg::NODE_W-1:0] out_neighbor_id,
  input logic signed [nrat_pkg::RSSI_W-1:0] out_average_rssi,
  input logic                               out_is_empty,
  input logic                               out_last_of_run
);

  // A stalled item stays in place.
  `NRAT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_neighbor_id) && $stable(out_average_rssi) && $stable(out_last_of_run), "result item changed while stalled")

  // An empty report is a single, final item with zero fields.
  `NRAT_ASSERT(a_empty_form, clk, rst_n, out_valid && out_is_empty |-> out_last_of_run && out_neighbor_id == '0 && out_average_rssi == '0, "malformed empty report")

  // A reported entry never carries the free-entry id.
  `NRAT_ASSERT_NEVER(a_no_free_id, clk, rst_n, out_valid && !out_is_empty && out_neighbor_id == '0, "report of a free entry")

  // While a report is still running, no new item is taken.
  `NRAT_ASSERT_NEVER(a_run_busy, clk, rst_n, out_valid && !out_last_of_run && in_ready, "input taken in the middle of a report")

endmodule

bind neighbor_rssi_average_table_core nrat_checker u_nrat_checker (.*);

// File: tb/neighbor_rssi_average_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor RSSI average table core: testbench
// Drives sample and report items through the input handshake, keeps its own
// copy of the neighbor table to predict every report result, and checks each
// result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module neighbor_rssi_average_table_core_tb;
  import nrat_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int POOL_MAX = 24;

  // One result item as the result channel carries it.
  typedef struct packed {
    logic [NODE_W-1:0] neighbor_id;
    logic [RSSI_W-1:0] average_rssi;
    logic              is_empty;
    logic              last_of_run;
  } nbr_result_t;

  // One row of the directed plan. A row may repeat its item, optionally
  // walking the sender id upward, and may carry a typed-in result.
  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] sender;
    logic [RSSI_W-1:0] rssi;
    logic [16:0]       reps;
    logic              walk_id;
    logic              typed;
    nbr_result_t       want;
  } plan_row_t;

  localparam nbr_result_t NO_RESULT = '{16'h0000, 8'h00, 1'b0, 1'b0};
  localparam nbr_result_t EMPTY_RESULT = '{16'h0000, 8'h00, 1'b1, 1'b1};
  localparam int PLAN_ROWS = 24;

  // RSSI values are written as raw bytes: 8'h80 is -128, 8'hFF is -1.
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b1, EMPTY_RESULT},
    '{KIND_SAMPLE, 16'h0000, 8'h05, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b1, EMPTY_RESULT},
    '{KIND_SAMPLE, 16'hFFFF, 8'h80, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b1,
      '{16'hFFFF, 8'h80, 1'b0, 1'b1}},
    '{KIND_SAMPLE, 16'h0001, 8'h7F, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h0001, 8'h7E, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h00AA, 8'hFD, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h00AA, 8'hFC, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h8000, 8'hFF, 17'd16, 1'b1, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h1234, 8'h05, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h800F, 8'h01, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h8003, 8'h7F, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h0000, 8'h7F, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b1, EMPTY_RESULT},
    '{KIND_SAMPLE, 16'h0042, 8'h80, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h0042, 8'h7F, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b1,
      '{16'h0042, 8'h00, 1'b0, 1'b1}},
    '{KIND_SAMPLE, 16'h5555, 8'h7F, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'hAAAA, 8'h80, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_SAMPLE, 16'h5555, 8'h00, 17'd1, 1'b0, 1'b0, NO_RESULT},
    '{KIND_REPORT, 16'h0000, 8'h00, 17'd1, 1'b0, 1'b0, NO_RESULT}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [NODE_W-1:0] in_sender_id;
  logic signed [RSSI_W-1:0] in_rssi_sample;
  logic              out_valid;
  logic              out_ready;
  logic [NODE_W-1:0] out_neighbor_id;
  logic signed [RSSI_W-1:0] out_average_rssi;
  logic              out_is_empty;
  logic              out_last_of_run;

  // Shadow copy of the neighbor table.
  logic [NODE_W-1:0]  shadow_node [ENTRIES];
  logic [COUNT_W-1:0] shadow_count [ENTRIES];
  int                 shadow_sum [ENTRIES];

  nbr_result_t awaited_results [$];
  nbr_result_t got;
  nbr_result_t want;

  int snd_idle_pct;
  int rcv_idle_pct;
  int errors;
  int items_sent;
  int reports_sent;
  int results_seen;
  int drops_seen;
  int restarts_seen;
  int stall_cycles;

  neighbor_rssi_average_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_sender_id     (in_sender_id),
    .in_rssi_sample   (in_rssi_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_neighbor_id  (out_neighbor_id),
    .out_average_rssi (out_average_rssi),
    .out_is_empty     (out_is_empty),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Forget every neighbor, as reset and the end of a report do.
  task automatic clear_shadow_table();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_node[i] = '0;
      shadow_count[i] = '0;
      shadow_sum[i] = 0;
    end
  endtask

  // Apply one accepted item to the shadow table. A report queues the
  // results it produces unless the caller has typed them in itself.
  task automatic track_neighbor_item(input logic kind, input logic [NODE_W-1:0] id,
                                     input logic [RSSI_W-1:0] rssi, input bit keep);
    int          slot;
    int          quotient;
    nbr_result_t res;
    nbr_result_t batch [$];
    slot = -1;
    if (kind == KIND_SAMPLE) begin
      if (id != '0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && shadow_node[i] == id) slot = i;
        if (slot >= 0) begin
          // A saturated count starts over before the sample is added.
          if (shadow_count[slot] == COUNT_MAX) begin
            shadow_count[slot] = '0;
            shadow_sum[slot] = 0;
            restarts_seen++;
          end
          shadow_count[slot] = shadow_count[slot] + 1'b1;
          shadow_sum[slot] = shadow_sum[slot] + int'($signed(rssi));
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && shadow_node[i] == '0) slot = i;
          if (slot >= 0) begin
            shadow_node[slot] = id;
            shadow_count[slot] = COUNT_W'(1);
            shadow_sum[slot] = int'($signed(rssi));
          end else begin
            drops_seen++;
          end
        end
      end
    end else begin
      // Report every used entry in table order; an empty table gives a marker.
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_node[i] != '0) begin
          quotient = 0;
          if (shadow_count[i] != '0) quotient = shadow_sum[i] / int'(shadow_count[i]);
          res.neighbor_id = shadow_node[i];
          res.average_rssi = quotient[RSSI_W-1:0];
          res.is_empty = 1'b0;
          res.last_of_run = 1'b0;
          batch.push_back(res);
        end
      end
      if (batch.size() == 0) batch.push_back(EMPTY_RESULT);
      else batch[batch.size()-1].last_of_run = 1'b1;
      if (keep) foreach (batch[i]) awaited_results.push_back(batch[i]);
      clear_shadow_table();
    end
  endtask

  // Offer one item, holding it steady until the block takes it.
  task automatic offer_item(input logic kind, input logic [NODE_W-1:0] id,
                            input logic [RSSI_W-1:0] rssi, input bit keep);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sender_id <= id;
    in_rssi_sample <= rssi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_REPORT) reports_sent++;
    track_neighbor_item(kind, id, rssi, keep);
  endtask

  // Hold the input side off until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Random traffic: mostly samples from a small pool of neighbors so that
  // entries get hit, fill up and overflow, with reports in between and a
  // share of zero ids and stray senders as noise.
  task automatic random_traffic(input int goal);
    logic [NODE_W-1:0] pool [POOL_MAX];
    int                pool_used;
    int                counted;
    int                pick;
    logic              kind;
    logic [NODE_W-1:0] id;
    logic [RSSI_W-1:0] rssi;
    counted = 0;
    pool_used = 0;
    while (counted < goal) begin
      if (pool_used == 0) begin
        pool_used = $urandom_range(4, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) pool[i] = NODE_W'($urandom_range(1, 65535));
      end
      pick = $urandom_range(0, 99);
      kind = (pick < 8) ? KIND_REPORT : KIND_SAMPLE;
      rssi = RSSI_W'($urandom_range(0, 255));
      if (pick < 8) id = NODE_W'($urandom_range(0, 65535));
      else if (pick < 11) id = '0;
      else if (pick < 18) id = NODE_W'($urandom_range(0, 65535));
      else id = pool[$urandom_range(0, pool_used - 1)];
      offer_item(kind, id, rssi, 1'b1);
      if (kind == KIND_REPORT && $urandom_range(0, 2) == 0) pool_used = 0;
      if (kind == KIND_REPORT || id != '0) counted++;
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  task automatic note_field(input string name, input logic [NODE_W-1:0] exp_val,
                            input logic [NODE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Random backpressure on the result side.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Compare every accepted result with the oldest one still awaited.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_neighbor_id, out_average_rssi, out_is_empty, out_last_of_run};
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, got);
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        note_field("neighbor_id", want.neighbor_id, got.neighbor_id);
        note_field("average_rssi", NODE_W'(want.average_rssi), NODE_W'(got.average_rssi));
        note_field("is_empty", NODE_W'(want.is_empty), NODE_W'(got.is_empty));
        note_field("last_of_run", NODE_W'(want.last_of_run), NODE_W'(got.last_of_run));
      end
    end
  end

  // Give up when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("neighbor_rssi_average_table_core verification failed");
      $finish;
    end
  end

  // Main sequence: reset, directed plan, then three mixes of traffic at different idle rates.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_SAMPLE;
    in_sender_id <= '0;
    in_rssi_sample <= '0;
    out_ready <= 1'b0;
    snd_idle_pct = 14;
    rcv_idle_pct = 50;
    errors = 0;
    items_sent = 0;
    reports_sent = 0;
    results_seen = 0;
    drops_seen = 0;
    restarts_seen = 0;
    stall_cycles = 0;
    clear_shadow_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, typed-in results where they are obvious.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < int'(DIRECTED_PLAN[r].reps); k++) begin
        offer_item(DIRECTED_PLAN[r].kind,
                   DIRECTED_PLAN[r].walk_id ? DIRECTED_PLAN[r].sender + NODE_W'(k)
                                            : DIRECTED_PLAN[r].sender,
                   DIRECTED_PLAN[r].rssi, !DIRECTED_PLAN[r].typed);
      end
      if (DIRECTED_PLAN[r].typed) awaited_results.push_back(DIRECTED_PLAN[r].want);
    end

    random_traffic(RANDOM_PER_PHASE);
    drain_results();
    snd_idle_pct = 50;
    rcv_idle_pct = 14;
    random_traffic(RANDOM_PER_PHASE);
    drain_results();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_traffic(RANDOM_PER_PHASE);
    offer_item(KIND_REPORT, '0, '0, 1'b1);

    // Let the last results come back, then watch for strays.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end

    $display("Run covered %0d items including %0d reports; %0d results compared, %0d errors.",
             items_sent, reports_sent, results_seen, errors);
    $display("Samples dropped on a full table: %0d; count restarts at saturation: %0d.",
             drops_seen, restarts_seen);
    if (errors == 0) begin
      $display("neighbor_rssi_average_table_core verification clean");
    end else begin
      $display("neighbor_rssi_average_table_core verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/nrat_pkg.sv
hw/rtl/nrat_ram.sv
hw/rtl/nrat_div.sv
hw/rtl/nrat_dp.sv
hw/rtl/nrat_ctrl.sv
hw/rtl/neighbor_rssi_average_table_core.sv
hw/rtl/nrat_checker.sv
tb/neighbor_rssi_average_table_core_tb.sv
